>>> src/assert_macros.svh
// Assertion macros used by the checker file of the project.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while in reset
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/sbcd_pkg.sv
// Types and constants of the sensor sample to BCD reading block.
// Used by the top level and its checker; depends on nothing.
package sbcd_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned REF_W      = 12;
  localparam int unsigned OFS_W      = 12;
  localparam int unsigned SUP_W      = 13;
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned PROD_W     = SAMPLE_W + REF_W;
  localparam int unsigned MV_W       = 12;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned DVD_W      = 32;

  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = DVD_W / DIV_STEPS;

  localparam int unsigned DIGITS     = 5;
  localparam int unsigned BCD_W      = 4 * DIGITS;
  localparam int unsigned DAB_STEPS  = 4;
  localparam int unsigned DAB_STAGES = VAL_W / DAB_STEPS;

  // product, millivolt, divider, select, digit stages
  localparam int unsigned LATENCY    = 3 + DIV_STAGES + DAB_STAGES;

  localparam logic [REF_W-1:0]   REF_RST   = 12'd1090;
  localparam logic [OFS_W-1:0]   OFS_RST   = 12'd500;
  localparam logic [SUP_W-1:0]   SUP_RST   = 13'd3300;
  localparam logic [SCALE_W-1:0] SCALE_RST = 8'd33;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_HUM  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF   = 3'd0,
    REG_OFS   = 3'd1,
    REG_SUP   = 3'd2,
    REG_SCALE = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic             op;
    logic             err;
    logic [VAL_W-1:0] tmp;
  } div_side_t;

endpackage

>>> src/sensor_sample_to_bcd_reading.sv
// Top level of the sensor sample to BCD reading block.
// Depends on sbcd_pkg.
//
// Usage:
//   Drive sample_i and operation_i (0 temperature, 1 humidity) with start_i high;
//   the item is taken at the rising edge where start_i is high and busy_o is low.
//   busy_o is low from the first clock edge after reset on, so one item a cycle.
//   Each item gives one result: done_o is high for exactly one cycle with value_o,
//   the five BCD digits and divide_error_o.
//   The pipeline runs through the product and millivolt stages, eight divider
//   stages of four dividend bits each over 32 bits, the scale-and-select stage
//   and four digit stages. Throughput is one item per cycle.
//   The receiver cannot stall; results leave whether taken or not.
//   Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
//   cfg_data_i; indexes beyond the register list are ignored. Write only while
//   no item is in flight.
//   Reset clears all items in flight and loads the register defaults; busy_o is
//   high and cfg_ready_o low until the first cycle after reset.
module sensor_sample_to_bcd_reading
  import sbcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic                  operation_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic [VAL_W-1:0]      value_o,
  output logic [3:0]            digit_ten_thousands_o,
  output logic [3:0]            digit_thousands_o,
  output logic [3:0]            digit_hundreds_o,
  output logic [3:0]            digit_tens_o,
  output logic [3:0]            digit_ones_o,
  output logic                  divide_error_o
);

  logic                 ready_q;
  logic                 accept;
  logic [LATENCY-1:0]   vld_q;

  logic [REF_W-1:0]     ref_q;
  logic [OFS_W-1:0]     ofs_q;
  logic [SUP_W-1:0]     sup_q;
  logic [SCALE_W-1:0]   scale_q;

  logic [PROD_W-1:0]    prod_q;
  logic                 pop_q;

  logic [MV_W-1:0]      mv;
  logic [DVD_W-1:0]     diff;
  logic [DVD_W-1:0]     dvd;

  logic [MV_W-1:0]      rem_q  [DIV_STAGES+1];
  logic [DVD_W-1:0]     dvd_q  [DIV_STAGES+1];
  logic [VAL_W-1:0]     quo_q  [DIV_STAGES+1];
  logic [MV_W-1:0]      dmv_q  [DIV_STAGES+1];
  div_side_t            side_q [DIV_STAGES+1];
  logic [MV_W-1:0]      rem_d  [DIV_STAGES];
  logic [DVD_W-1:0]     dvd_d  [DIV_STAGES];
  logic [VAL_W-1:0]     quo_d  [DIV_STAGES];

  logic [VAL_W-1:0]     mul;
  logic [VAL_W-1:0]     sel_val;
  div_side_t            last_side;

  logic [BCD_W-1:0]     bcd_q  [DAB_STAGES+1];
  logic [VAL_W-1:0]     bin_q  [DAB_STAGES+1];
  logic [VAL_W-1:0]     dval_q [DAB_STAGES+1];
  logic                 derr_q [DAB_STAGES+1];
  logic [BCD_W-1:0]     bcd_d  [DAB_STAGES];
  logic [VAL_W-1:0]     bin_d  [DAB_STAGES];

  assign busy_o      = !ready_q;
  assign cfg_ready_o = ready_q;
  assign accept      = start_i && ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      vld_q   <= '0;
    end else begin
      ready_q <= 1'b1;
      vld_q   <= {vld_q[LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= REF_RST;
      ofs_q   <= OFS_RST;
      sup_q   <= SUP_RST;
      scale_q <= SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_REF:   ref_q   <= cfg_data_i[REF_W-1:0];
        REG_OFS:   ofs_q   <= cfg_data_i[OFS_W-1:0];
        REG_SUP:   sup_q   <= cfg_data_i[SUP_W-1:0];
        REG_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // millivolts, supply minus millivolts difference and divider dividend
  assign mv   = prod_q[PROD_W-1 -: MV_W];
  assign diff = DVD_W'(sup_q) - DVD_W'(mv);
  assign dvd  = {diff[DVD_W-4:0], 3'b000} + {diff[DVD_W-2:0], 1'b0};

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [MV_W-1:0]  rem_v;
    logic [DVD_W-1:0] dvd_v;
    logic [VAL_W-1:0] quo_v;
    logic [MV_W:0]    trial;

    always_comb begin
      rem_v = rem_q[s];
      dvd_v = dvd_q[s];
      quo_v = quo_q[s];
      trial = '0;
      for (int b = 0; b < DIV_STEPS; b++) begin
        trial = {rem_v, dvd_v[DVD_W-1]};
        dvd_v = {dvd_v[DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, dmv_q[s]}) begin
          rem_v = MV_W'(trial - {1'b0, dmv_q[s]});
          quo_v = {quo_v[VAL_W-2:0], 1'b1};
        end else begin
          rem_v = trial[MV_W-1:0];
          quo_v = {quo_v[VAL_W-2:0], 1'b0};
        end
      end
    end

    assign rem_d[s] = rem_v;
    assign dvd_d[s] = dvd_v;
    assign quo_d[s] = quo_v;
  end

  // scale the ratio and pick the reading
  assign last_side = side_q[DIV_STAGES];
  assign mul = quo_q[DIV_STAGES] * VAL_W'(scale_q);

  always_comb begin
    priority if (last_side.op == OP_TEMP) begin
      sel_val = last_side.tmp;
    end else if (last_side.err) begin
      sel_val = '0;
    end else begin
      sel_val = mul;
    end
  end

  for (genvar s = 0; s < DAB_STAGES; s++) begin : g_dab
    logic [BCD_W-1:0] bcd_v;
    logic [VAL_W-1:0] bin_v;

    always_comb begin
      bcd_v = bcd_q[s];
      bin_v = bin_q[s];
      for (int k = 0; k < DAB_STEPS; k++) begin
        for (int d = 0; d < DIGITS; d++) begin
          if (bcd_v[4*d +: 4] >= 4'd5) begin
            bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + 4'd3;
          end
        end
        {bcd_v, bin_v} = {bcd_v[BCD_W-2:0], bin_v, 1'b0};
      end
    end

    assign bcd_d[s] = bcd_v;
    assign bin_d[s] = bin_v;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(sample_i) * PROD_W'(ref_q);
    pop_q  <= operation_i;

    rem_q[0]      <= '0;
    dvd_q[0]      <= dvd;
    quo_q[0]      <= '0;
    dmv_q[0]      <= mv;
    side_q[0].op  <= pop_q;
    side_q[0].err <= (pop_q == OP_HUM) && (mv == '0);
    side_q[0].tmp <= VAL_W'(mv) - VAL_W'(ofs_q);

    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_q[s+1]  <= rem_d[s];
      dvd_q[s+1]  <= dvd_d[s];
      quo_q[s+1]  <= quo_d[s];
      dmv_q[s+1]  <= dmv_q[s];
      side_q[s+1] <= side_q[s];
    end

    bcd_q[0]  <= '0;
    bin_q[0]  <= sel_val;
    dval_q[0] <= sel_val;
    derr_q[0] <= last_side.err;

    for (int s = 0; s < DAB_STAGES; s++) begin
      bcd_q[s+1]  <= bcd_d[s];
      bin_q[s+1]  <= bin_d[s];
      dval_q[s+1] <= dval_q[s];
      derr_q[s+1] <= derr_q[s];
    end
  end

  assign done_o                = vld_q[LATENCY-1];
  assign value_o               = dval_q[DAB_STAGES];
  assign digit_ten_thousands_o = bcd_q[DAB_STAGES][19:16];
  assign digit_thousands_o     = bcd_q[DAB_STAGES][15:12];
  assign digit_hundreds_o      = bcd_q[DAB_STAGES][11:8];
  assign digit_tens_o          = bcd_q[DAB_STAGES][7:4];
  assign digit_ones_o          = bcd_q[DAB_STAGES][3:0];
  assign divide_error_o        = derr_q[DAB_STAGES];

endmodule

>>> src/sbcd_checker.sv
// Port-level checker of the sensor sample to BCD reading block, with its bind.
// Depends on sbcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbcd_checker
  import sbcd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  operation_i,
  input logic                  done_o,
  input logic [VAL_W-1:0]      value_o,
  input logic [3:0]            digit_ten_thousands_o,
  input logic [3:0]            digit_thousands_o,
  input logic [3:0]            digit_hundreds_o,
  input logic [3:0]            digit_tens_o,
  input logic [3:0]            digit_ones_o,
  input logic                  divide_error_o
);

  logic zero_reading;
  logic digits_ok;

  assign zero_reading = (value_o == '0) && (digit_ones_o == '0) && (digit_tens_o == '0) &&
                        (digit_hundreds_o == '0) && (digit_thousands_o == '0) &&
                        (digit_ten_thousands_o == '0);
  assign digits_ok    = (digit_ones_o <= DIGIT_MAX) && (digit_tens_o <= DIGIT_MAX) &&
                        (digit_hundreds_o <= DIGIT_MAX) && (digit_thousands_o <= DIGIT_MAX) &&
                        (digit_ten_thousands_o <= DIGIT_MAX);

  `ASSERT_IMP(a_done_from_item, done_o, $past(start_i && !busy_o, LATENCY))

  `ASSERT_IMP(a_err_only_humidity, done_o && divide_error_o, $past(operation_i, LATENCY))

  `ASSERT_IMP(a_err_zero_reading, done_o && divide_error_o, zero_reading)

  `ASSERT_IMP(a_digits_decimal, done_o, digits_ok)

  `ASSERT_NXT(a_stays_ready, !busy_o, !busy_o)

endmodule

bind sensor_sample_to_bcd_reading sbcd_checker u_sbcd_checker (.*);
